>>> rtl/bbcm_pkg.sv
// ----------------------------------------------------------------------------
// bbcm_pkg
// Shared widths, register indexes and cosine series constants for the radial
// bulge coordinate map.
// ----------------------------------------------------------------------------
package bbcm_pkg;

    localparam int DEF_MAX_DIM   = 1024;
    localparam int DEF_FRAC_BITS = 8;

    localparam int PIX_W  = 10;
    localparam int DIM_W  = 11;
    localparam int GAIN_W = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int OUT_W  = 19;

    localparam int DIV_STEPS  = 16;
    localparam int SQRT_STEPS = 16;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BULGE_GAIN   = 2'd2
    } cfg_reg_t;

    // Taylor coefficients of cos(pi*r) in Q15
    localparam logic signed [21:0] COS_C1 = 22'sd161704;
    localparam logic signed [21:0] COS_C2 = 22'sd132996;
    localparam logic signed [21:0] COS_C3 = 22'sd43754;
    localparam logic signed [21:0] COS_C4 = 22'sd7711;

    localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;

endpackage

>>> rtl/barrel_bulge_coordinate_map_top.sv
// ----------------------------------------------------------------------------
// barrel_bulge_coordinate_map_top
// Maps a destination pixel to the source position of a radial bulge warp.
//
// Usage:
//   Input channel in_valid/in_ready carries one item (pixel_x, pixel_y).
//   Output channel out_valid/out_ready carries one item (source_x, source_y),
//   signed, FRAC_BITS fractional bits, saturated.
//   Config port: cfg_write, cfg_index, cfg_data; it must be written only
//   while idle by the user; the block does not enforce this. Throughput: one
//   item per clock while the skid register is empty. The pipeline runs a
//   16-step restoring divider, a 16-step square root and a cosine series
//   with one multiplier per stage. Reset clears all stage valid bits and the
//   output/skid valid flags and loads width 64, height 64, gain 0.5.
//   When the receiver stalls, one more item lands in a skid register, then
//   in_ready drops and the whole pipeline holds until the skid drains.
// ----------------------------------------------------------------------------
module barrel_bulge_coordinate_map_top
    import bbcm_pkg::*;
#(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PIX_W-1:0]        pixel_x,
    input  logic [PIX_W-1:0]        pixel_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] source_x,
    output logic signed [OUT_W-1:0] source_y
);

    localparam int SHIFT   = 30 - FRAC_BITS;
    localparam int ST_UV   = DIV_STEPS + 1;
    localparam int ST_SQ   = ST_UV + 1;
    localparam int ST_SUM  = ST_SQ + 1;
    localparam int ST_ROOT = ST_SUM + SQRT_STEPS;
    localparam int ST_R2   = ST_ROOT + 1;
    localparam int ST_Q    = ST_R2 + 1;
    localparam int ST_P1   = ST_Q + 1;
    localparam int ST_P2   = ST_P1 + 1;
    localparam int ST_P3   = ST_P2 + 1;
    localparam int ST_P4   = ST_P3 + 1;
    localparam int ST_COS  = ST_P4 + 1;
    localparam int ST_KC   = ST_COS + 1;
    localparam int ST_S    = ST_KC + 1;
    localparam int ST_NS   = ST_S + 1;
    localparam int ST_POS  = ST_NS + 1;
    localparam int ST_OUT  = ST_POS + 1;
    localparam int NST     = ST_OUT + 1;

    localparam logic [49:0] HALF = 50'(1) << (SHIFT - 1);

    function automatic logic signed [21:0] rnd15(input logic signed [35:0] x);
        logic signed [35:0] t;
        t = x + 36'sd16384;
        return 22'(t >>> 15);
    endfunction

    // configuration
    logic [DIM_W-1:0]         width_reg, height_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    logic [DIM_W-1:0]         dim [0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd64;
            height_reg <= 11'd64;
            gain_reg   <= 16'sd2048;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_BULGE_GAIN:   gain_reg   <= $signed(cfg_data[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        dim[0] = width_reg;
        dim[1] = height_reg;
        for (int l = 0; l < 2; l++)
        begin
            if (dim[l] == '0)
                dim[l] = 11'd1;
            else if (32'(dim[l]) > MAX_DIM)
                dim[l] = DIM_W'(MAX_DIM);
        end
    end

    // pipeline control
    logic             en;
    logic             push;
    logic [NST-1:0]   vld_reg;
    logic             out_valid_reg, skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;
    assign push     = en && vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // stage registers (lane 0 = x, lane 1 = y)
    logic [DIM_W-1:0]        dv_rem_reg  [0:1][0:DIV_STEPS];
    logic [15:0]             dv_lq_reg   [0:1][0:DIV_STEPS];
    logic                    dv_sat_reg  [0:1][0:DIV_STEPS];
    logic [DIM_W-1:0]        dv_rem_next [0:1][0:DIV_STEPS];
    logic [15:0]             dv_lq_next  [0:1][0:DIV_STEPS];
    logic signed [15:0]      uv_reg      [0:1][ST_UV:ST_S];
    logic signed [15:0]      uv_next     [0:1];
    logic [31:0]             sq_reg      [0:1];
    logic [31:0]             sr_a_reg    [0:SQRT_STEPS];
    logic [17:0]             sr_rem_reg  [0:SQRT_STEPS];
    logic [15:0]             sr_root_reg [0:SQRT_STEPS];
    logic [31:0]             sr_a_next   [0:SQRT_STEPS];
    logic [17:0]             sr_rem_next [0:SQRT_STEPS];
    logic [15:0]             sr_root_next[0:SQRT_STEPS];
    logic [ST_KC:ST_R2]      big_reg;
    logic                    big_next;
    logic [28:0]             r2_reg, r2_next;
    logic [13:0]             q_reg       [ST_Q:ST_P3];
    logic signed [35:0]      p1_reg, p2_reg, p3_reg, p4_reg;
    logic [15:0]             cos_reg, cos_next;
    logic signed [32:0]      kc_reg;
    logic signed [19:0]      s_reg, s_next;
    logic signed [35:0]      ns_reg      [0:1];
    logic signed [48:0]      pos_reg     [0:1];
    logic signed [OUT_W-1:0] res_reg     [0:1];
    logic signed [OUT_W-1:0] res_next    [0:1];
    logic signed [14:0]      q_s         [ST_Q:ST_P3];

    // q travels with its item through the series stages
    always_comb
    begin
        for (int i = ST_Q; i <= ST_P3; i++)
            q_s[i] = $signed({1'b0, q_reg[i]});
    end

    always_comb
    begin
        logic [24:0]        num;
        logic [DIM_W:0]     t;
        logic               ge;
        logic signed [16:0] n;
        for (int l = 0; l < 2; l++)
        begin
            num = {(l == 0) ? pixel_x : pixel_y, 15'b0} + 25'(dim[l] >> 1);
            dv_rem_next[l][0] = {2'b0, num[24:16]};
            dv_lq_next[l][0]  = num[15:0];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                t  = {dv_rem_reg[l][j], dv_lq_reg[l][j][15]};
                ge = t >= {1'b0, dim[l]};
                dv_rem_next[l][j+1] = ge ? DIM_W'(t - {1'b0, dim[l]}) : t[DIM_W-1:0];
                dv_lq_next[l][j+1]  = {dv_lq_reg[l][j][14:0], ge};
            end
            n = $signed({1'b0, dv_lq_reg[l][DIV_STEPS]}) - 17'sd16384;
            if (dv_sat_reg[l][DIV_STEPS] || n > 17'sd32767)
                uv_next[l] = 16'sh7FFF;
            else
                uv_next[l] = n[15:0];
        end
    end

    always_comb
    begin
        logic [19:0] tr, trial;
        logic        ge;
        sr_a_next[0]    = sq_reg[0] + sq_reg[1];
        sr_rem_next[0]  = '0;
        sr_root_next[0] = '0;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            tr    = {sr_rem_reg[i], sr_a_reg[i][31:30]};
            trial = {2'b0, sr_root_reg[i], 2'b01};
            ge    = tr >= trial;
            sr_rem_next[i+1]  = ge ? 18'(tr - trial) : tr[17:0];
            sr_root_next[i+1] = {sr_root_reg[i][14:0], ge};
            sr_a_next[i+1]    = {sr_a_reg[i][29:0], 2'b0};
        end
    end

    always_comb
    begin
        logic [14:0] rf;
        big_next = sr_root_reg[SQRT_STEPS] > 16'd16384;
        rf       = big_next ? '0 : sr_root_reg[SQRT_STEPS][14:0];
        r2_next  = 29'(rf * rf);
    end

    always_comb
    begin
        logic signed [21:0] c;
        c = 22'sd32768 - rnd15(p4_reg);
        if (c < 0)
            cos_next = '0;
        else if (c > 22'sd32768)
            cos_next = 16'd32768;
        else
            cos_next = c[15:0];
    end

    always_comb
    begin
        logic signed [33:0] kmag, rr, sv, sw;
        logic               neg;
        neg  = kc_reg < 0;
        kmag = neg ? -34'(kc_reg) : 34'(kc_reg);
        rr   = (kmag + 34'sd2048) >>> 12;
        sv   = neg ? -rr : rr;
        sw   = 34'sd32768 - sv;
        s_next = big_reg[ST_KC] ? 20'sd32768 : 20'(sw);
    end

    always_comb
    begin
        logic [49:0]        mag, rm;
        logic signed [49:0] o;
        logic               neg;
        for (int l = 0; l < 2; l++)
        begin
            neg = pos_reg[l] < 0;
            mag = neg ? 50'(-50'(pos_reg[l])) : 50'(pos_reg[l]);
            rm  = (mag + HALF) >> SHIFT;
            o   = neg ? -$signed(rm) : $signed(rm);
            if (o < 50'(OUT_MIN))
                res_next[l] = OUT_MIN;
            else if (o > 50'(OUT_MAX))
                res_next[l] = OUT_MAX;
            else
                res_next[l] = o[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                for (int j = 0; j <= DIV_STEPS; j++)
                begin
                    dv_rem_reg[l][j] <= dv_rem_next[l][j];
                    dv_lq_reg[l][j]  <= dv_lq_next[l][j];
                end
                dv_sat_reg[l][0] <= dv_rem_next[l][0] >= dim[l];
                for (int j = 1; j <= DIV_STEPS; j++)
                    dv_sat_reg[l][j] <= dv_sat_reg[l][j-1];
                uv_reg[l][ST_UV] <= uv_next[l];
                for (int i = ST_UV + 1; i <= ST_S; i++)
                    uv_reg[l][i] <= uv_reg[l][i-1];
                sq_reg[l]  <= 32'(uv_reg[l][ST_UV] * uv_reg[l][ST_UV]);
                ns_reg[l]  <= 36'(uv_reg[l][ST_S] * s_reg);
                pos_reg[l] <= 49'((37'(ns_reg[l]) + 37'sd536870912)
                                  * $signed({1'b0, dim[l]}));
                res_reg[l] <= res_next[l];
            end
            for (int i = 0; i <= SQRT_STEPS; i++)
            begin
                sr_a_reg[i]    <= sr_a_next[i];
                sr_rem_reg[i]  <= sr_rem_next[i];
                sr_root_reg[i] <= sr_root_next[i];
            end
            big_reg <= {big_reg[ST_KC-1:ST_R2], big_next};
            r2_reg  <= r2_next;
            q_reg[ST_Q] <= 14'((r2_reg + 29'd16384) >> 15);
            for (int i = ST_Q + 1; i <= ST_P3; i++)
                q_reg[i] <= q_reg[i-1];
            p1_reg  <= 36'(COS_C4 * q_s[ST_Q]);
            p2_reg  <= 36'((COS_C3 - rnd15(p1_reg)) * q_s[ST_P1]);
            p3_reg  <= 36'((COS_C2 - rnd15(p2_reg)) * q_s[ST_P2]);
            p4_reg  <= 36'((COS_C1 - rnd15(p3_reg)) * q_s[ST_P3]);
            cos_reg <= cos_next;
            kc_reg  <= 33'(gain_reg * $signed({1'b0, cos_reg}));
            s_reg   <= s_next;
        end
    end

    // output register and skid
    logic signed [OUT_W-1:0] out_x_reg, out_y_reg, skid_x_reg, skid_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (push)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (push)
            begin
                skid_x_reg <= res_reg[0];
                skid_y_reg <= res_reg[1];
            end
        end
        else if (skid_valid_reg)
        begin
            out_x_reg <= skid_x_reg;
            out_y_reg <= skid_y_reg;
        end
        else if (push)
        begin
            out_x_reg <= res_reg[0];
            out_y_reg <= res_reg[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign source_x  = out_x_reg;
    assign source_y  = out_y_reg;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output is empty");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> !skid_valid_reg && out_valid_reg)
        else $error("skid did not drain into output");
`endif

endmodule

>>> test/barrel_bulge_coordinate_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrel_bulge_coordinate_map_checker
// Watches the config port and both item channels of the bulge map, predicts
// the source position of every accepted pixel and compares it field by field
// with the items leaving the block, oldest first.
// ----------------------------------------------------------------------------
module barrel_bulge_coordinate_map_checker
    import bbcm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [PIX_W-1:0]        pixel_x,
    input  logic [PIX_W-1:0]        pixel_y,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [OUT_W-1:0] source_x,
    input  logic signed [OUT_W-1:0] source_y,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic signed [OUT_W-1:0] src_x;
        logic signed [OUT_W-1:0] src_y;
    } source_pos_t;

    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    source_pos_t              expected_pos[$];

    function automatic longint clamp_dim(input logic [DIM_W-1:0] r);
        longint d;
        d = r;
        if (d < 1) d = 1;
        if (d > DEF_MAX_DIM) d = DEF_MAX_DIM;
        return d;
    endfunction

    function automatic longint center_norm(input logic [PIX_W-1:0] p, input longint d);
        longint n;
        n = ((longint'(p) <<< 15) + (d >>> 1)) / d - 16384;
        if (n > 32767) n = 32767;
        return n;
    endfunction

    function automatic longint floor_sqrt(input longint a);
        longint res;
        longint t;
        res = 0;
        for (int b = 16; b >= 0; b--) begin
            t = res | (longint'(1) <<< b);
            if (t * t <= a) res = t;
        end
        return res;
    endfunction

    function automatic longint q15_mul(input longint a, input longint q);
        return (a * q + 16384) >>> 15;
    endfunction

    function automatic longint round_shift(input longint v, input int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -(((-v) + half) >>> n);
    endfunction

    function automatic longint cos_pi(input longint r);
        longint q;
        longint p;
        q = (r * r + 16384) >>> 15;
        p = COS_C4;
        p = COS_C3 - q15_mul(p, q);
        p = COS_C2 - q15_mul(p, q);
        p = COS_C1 - q15_mul(p, q);
        p = 32768 - q15_mul(p, q);
        if (p < 0) p = 0;
        if (p > 32768) p = 32768;
        return p;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_pixels(input longint n, input longint s,
                                                          input longint d);
        longint o;
        o = round_shift((n * s + (longint'(1) <<< 29)) * d, 30 - DEF_FRAC_BITS);
        if (o < OUT_MIN) o = OUT_MIN;
        if (o > OUT_MAX) o = OUT_MAX;
        return o[OUT_W-1:0];
    endfunction

    function automatic source_pos_t bulge_source(input logic [PIX_W-1:0] x,
                                                 input logic [PIX_W-1:0] y);
        longint w, h, k, u, v, r, s;
        source_pos_t pos;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        k = gain_reg;
        u = center_norm(x, w);
        v = center_norm(y, h);
        r = floor_sqrt(u * u + v * v);
        s = 32768;
        if (r <= 16384) s = 32768 - round_shift(k * cos_pi(r), 12);
        pos.src_x = to_pixels(u, s, w);
        pos.src_y = to_pixels(v, s, h);
        return pos;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        source_pos_t exp_pos;
        if (!rst_n)
        begin
            width_reg  <= 11'd64;
            height_reg <= 11'd64;
            gain_reg   <= 16'sd2048;
            errors     <= 0;
            pending    <= 0;
            expected_pos.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    REG_BULGE_GAIN:   gain_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_pos.push_back(bulge_source(pixel_x, pixel_y));
            if (out_valid && out_ready)
            begin
                if (expected_pos.size() == 0)
                begin
                    $error("unexpected item: source_x %0d source_y %0d", source_x, source_y);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_pos = expected_pos.pop_front();
                    if (source_x !== exp_pos.src_x || source_y !== exp_pos.src_y)
                        errors <= errors + 1;
                    if (source_x !== exp_pos.src_x)
                        $error("source_x: expected %0d, got %0d", exp_pos.src_x, source_x);
                    if (source_y !== exp_pos.src_y)
                        $error("source_y: expected %0d, got %0d", exp_pos.src_y, source_y);
                end
            end
            pending <= expected_pos.size();
        end
    end

endmodule

>>> test/barrel_bulge_coordinate_map_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrel_bulge_coordinate_map_top_test
// Drives pixel coordinates into the bulge map under several sizes and gains,
// with random sender gaps and receiver stalls plus one long output hold-off,
// and reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module barrel_bulge_coordinate_map_top_test;
    import bbcm_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 80;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [PIX_W-1:0]        pixel_x;
    logic [PIX_W-1:0]        pixel_y;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] source_x;
    logic signed [OUT_W-1:0] source_y;
    int                      errors;
    int                      pending;

    int      idle_pct;
    int      stall_pct;
    bit      hold_req;
    bit      hold_taken;
    int      hold_left;
    int      quiet_cycles;
    int      cur_w;
    int      cur_h;

    barrel_bulge_coordinate_map_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .source_x  (source_x),
        .source_y  (source_y)
    );

    barrel_bulge_coordinate_map_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .source_x  (source_x),
        .source_y  (source_y),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        out_ready  = 1'b0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_left  = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_patch(input int w, input int h, input logic [CFG_W-1:0] gain);
        cfg_put(REG_IMAGE_WIDTH, CFG_W'(w));
        cfg_put(REG_IMAGE_HEIGHT, CFG_W'(h));
        cfg_put(REG_BULGE_GAIN, gain);
        cur_w = (w % 2048 == 0) ? 1 : ((w % 2048 > 1024) ? 1024 : w % 2048);
        cur_h = (h % 2048 == 0) ? 1 : ((h % 2048 > 1024) ? 1024 : h % 2048);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= x;
        pixel_y  <= y;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic random_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_pixel(PIX_W'($urandom_range(1023)), PIX_W'($urandom_range(1023)));
            else
                send_pixel(PIX_W'($urandom_range(cur_w - 1)),
                           PIX_W'($urandom_range(cur_h - 1)));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel_x   = '0;
        pixel_y   = '0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        cur_w     = 64;
        cur_h     = 64;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset patch: corners, center, outside, bit extremes
        send_pixel(0, 0);
        send_pixel(32, 32);
        send_pixel(63, 63);
        send_pixel(63, 0);
        send_pixel(0, 63);
        send_pixel(16, 16);
        send_pixel(48, 32);
        send_pixel(1023, 1023);
        send_pixel(1023, 0);
        send_pixel(0, 1023);
        send_pixel(682, 341);
        drain();

        // zero and oversized dimensions, extreme gains, ignored index
        set_patch(0, 2047, 16'h8000);
        cfg_put(REG_SPARE, 16'h0005);
        send_pixel(0, 0);
        send_pixel(0, 512);
        send_pixel(1023, 1023);
        send_pixel(1, 1023);
        drain();
        set_patch(1024, 1024, 16'h7FFF);
        send_pixel(512, 512);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(256, 768);
        send_pixel(682, 341);
        send_pixel(1, 1022);
        drain();
        set_patch(16'hF840, 1, 16'h0000);
        send_pixel(32, 0);
        send_pixel(5, 9);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            case (ph)
                0: set_patch(64, 64, 16'd2048);
                1: set_patch(1, 1, 16'h8000);
                2: set_patch(1024, 1024, 16'h7FFF);
                3: set_patch(37, 200, 16'hF000);
                default: set_patch($urandom_range(1, 1024), $urandom_range(1, 1024),
                                   CFG_W'($urandom_range(16'hFFFF)));
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            random_pixels(165);
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bbcm_pkg.sv
rtl/barrel_bulge_coordinate_map_top.sv
test/barrel_bulge_coordinate_map_checker.sv
test/barrel_bulge_coordinate_map_top_test.sv
